@@ rtl/text_console_with_status_input_macros.svh @@
// assertion macros for the text console checker
`ifndef TEXT_CONSOLE_WITH_STATUS_INPUT_MACROS_SVH
`define TEXT_CONSOLE_WITH_STATUS_INPUT_MACROS_SVH

// antecedent holds, consequent in the same cycle
`define TCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: label");

// antecedent holds, consequent in the next cycle
`define TCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: label");

`endif

@@ rtl/tcs_pkg.sv @@
// shared constants, codes and state type of the text console
`timescale 1ns / 1ps

package tcs_pkg;

    localparam int COLUMNS      = 80;
    localparam int CONSOLE_ROWS = 24;
    localparam int CELL_COUNT   = COLUMNS * (CONSOLE_ROWS + 1);
    localparam int STATUS_START = COLUMNS * CONSOLE_ROWS;
    localparam int LINE_DEPTH   = COLUMNS + 1;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(CONSOLE_ROWS);
    localparam int LINE_W = $clog2(LINE_DEPTH);

    localparam logic [ADDR_W-1:0] STATUS_BASE = ADDR_W'(STATUS_START);
    localparam logic [ADDR_W-1:0] SCROLL_LEN  = ADDR_W'(STATUS_START - COLUMNS);

    // opcodes
    localparam logic [2:0] OP_WRITE_CHAR   = 3'd0;
    localparam logic [2:0] OP_KEY          = 3'd1;
    localparam logic [2:0] OP_BEGIN_INPUT  = 3'd2;
    localparam logic [2:0] OP_STATUS_WRITE = 3'd3;
    localparam logic [2:0] OP_READ_CELL    = 3'd4;
    localparam logic [2:0] OP_READ_LINE    = 3'd5;

    // register indexes
    localparam logic [1:0] REG_SCREEN_COLOR = 2'd0;
    localparam logic [1:0] REG_STATUS_COLOR = 2'd1;
    localparam logic [1:0] REG_PROMPT_COLOR = 2'd2;

    // reset colors
    localparam logic [7:0] SCREEN_COLOR_RST = 8'd7;
    localparam logic [7:0] STATUS_COLOR_RST = 8'd112;
    localparam logic [7:0] PROMPT_COLOR_RST = 8'd31;

    // character codes
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    // normal status text
    localparam int NORMAL_LEN = 12;
    localparam int NT_W       = $clog2(NORMAL_LEN);
    localparam logic [7:0] NORMAL_TEXT [NORMAL_LEN] = '{
        8'h2d, 8'h2d, 8'h20, 8'h4e, 8'h4f, 8'h52,
        8'h4d, 8'h41, 8'h4c, 8'h20, 8'h2d, 8'h2d
    };

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_CAP_RD,
        ST_CAP_WR,
        ST_CAP_END,
        ST_FILL,
        ST_RD_CELL,
        ST_RD_LINE,
        ST_RESP
    } state_t;

endpackage

@@ rtl/text_console_with_status_input.sv @@
// text console top level: sequencer around the screen and line memories
// steps: reads add a read state; key edits and status writes read, then write a status
//   cell; begin_input fills the status row; enter copies the edit text to the line
//   buffer, then refills the row; a scroll moves one cell a cycle; other items load
//   the result directly; one item at a time; input reopens the cycle after the result
//   is loaded; reset: async active low, then a pass clears memories, sets status text
`timescale 1ns / 1ps

module text_console_with_status_input
    import tcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [7:0]  char_code,
    input  logic [7:0]  attr,
    input  logic [10:0] index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] cursor_pos,
    output logic [15:0] cell_word,
    output logic [7:0]  line_char,
    output logic        line_ready,
    output logic        in_input_mode
);

    state_t state_reg, state_next;

    logic [7:0]        status_color_reg, prompt_color_reg;
    logic [COL_W-1:0]  console_col_reg, console_col_next;
    logic [ROW_W-1:0]  console_row_reg, console_row_next;
    logic [COL_W-1:0]  edit_col_reg, edit_col_next;
    logic [COL_W-1:0]  edit_start_reg, edit_start_next;
    logic              line_done_reg, line_done_next;
    logic              input_active_reg, input_active_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] rmw_addr_reg, rmw_addr_next;
    logic [7:0]        rmw_char_reg, rmw_char_next;
    logic [7:0]        fill_color_reg, fill_color_next;
    logic              fill_normal_reg, fill_normal_next;
    logic [15:0]       cell_reg, cell_next;
    logic [7:0]        lch_reg, lch_next;
    logic              out_valid_reg, out_valid_next;
    logic [10:0]       cursor_out_reg;
    logic [15:0]       cell_out_reg;
    logic [7:0]        lch_out_reg;
    logic              ready_out_reg, mode_out_reg;

    logic              s_we;
    logic [ADDR_W-1:0] s_waddr, s_raddr;
    logic [15:0]       s_wdata, s_rdata;
    logic              l_we;
    logic [LINE_W-1:0] l_waddr, l_raddr;
    logic [7:0]        l_wdata, l_rdata;

    logic              accept, resp_load;
    logic [ADDR_W-1:0] cursor_lin, status_col_addr;
    logic [COL_W:0]    cap_col;
    logic              row_last, col_last, ch_print, idx_col_ok;
    logic [7:0]        text_char;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign resp_load = (state_reg == ST_RESP) && (!out_valid_reg || !out_stall);
    assign in_stall  = (state_reg != ST_IDLE);

    // shared decode
    assign row_last   = (console_row_reg == ROW_W'(CONSOLE_ROWS - 1));
    assign col_last   = (console_col_reg == COL_W'(COLUMNS - 1));
    assign ch_print   = (char_code >= CH_SPACE) && (char_code <= CH_DEL);
    assign idx_col_ok = (index < 11'(COLUMNS));
    assign cursor_lin = ADDR_W'(console_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(console_col_reg);
    assign cap_col    = (COL_W+1)'(edit_start_reg) + (COL_W+1)'(cnt_reg[LINE_W-1:0]);
    assign status_col_addr = STATUS_BASE + ADDR_W'(cnt_reg - STATUS_BASE);
    assign text_char  = NORMAL_TEXT[cnt_reg[NT_W-1:0]];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_color_reg <= STATUS_COLOR_RST;
            prompt_color_reg <= PROMPT_COLOR_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_STATUS_COLOR)
            begin
                status_color_reg <= cfg_data;
            end
            if (cfg_index == REG_PROMPT_COLOR)
            begin
                prompt_color_reg <= cfg_data;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESP;
                    priority if (opcode == OP_WRITE_CHAR)
                    begin
                        if (row_last && ((char_code == CH_NL) ||
                                         (char_code >= CH_SPACE && col_last)))
                        begin
                            state_next = ST_SCROLL;
                        end
                    end
                    else if (opcode == OP_KEY && input_active_reg)
                    begin
                        if (char_code == CH_NL)
                        begin
                            state_next = ST_CAP_RD;
                        end
                        else if (char_code == CH_BS && edit_col_reg > edit_start_reg)
                        begin
                            state_next = ST_RMW_RD;
                        end
                        else if (ch_print && edit_col_reg < COL_W'(COLUMNS - 1))
                        begin
                            state_next = ST_RMW_RD;
                        end
                    end
                    else if (opcode == OP_BEGIN_INPUT)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (opcode == OP_STATUS_WRITE && idx_col_ok)
                    begin
                        state_next = ST_RMW_RD;
                    end
                    else if (opcode == OP_READ_CELL && index < 11'(CELL_COUNT))
                    begin
                        state_next = ST_RD_CELL;
                    end
                    else if (opcode == OP_READ_LINE && index < 11'(LINE_DEPTH))
                    begin
                        state_next = ST_RD_LINE;
                    end
                end
            end
            ST_SCROLL:
            begin
                if (cnt_reg == STATUS_BASE)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RMW_RD:  state_next = ST_RMW_WR;
            ST_RMW_WR:  state_next = ST_RESP;
            ST_CAP_RD:
            begin
                state_next = (cap_col >= (COL_W+1)'(COLUMNS)) ? ST_CAP_END : ST_CAP_WR;
            end
            ST_CAP_WR:
            begin
                state_next = (s_rdata[7:0] == 8'd0) ? ST_CAP_END : ST_CAP_RD;
            end
            ST_CAP_END: state_next = ST_FILL;
            ST_FILL:
            begin
                if (cnt_reg == ADDR_W'(COLUMNS - 1))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RD_CELL: state_next = ST_RESP;
            ST_RD_LINE: state_next = ST_RESP;
            ST_RESP:
            begin
                if (resp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        console_col_next  = console_col_reg;
        console_row_next  = console_row_reg;
        edit_col_next     = edit_col_reg;
        edit_start_next   = edit_start_reg;
        line_done_next    = line_done_reg;
        input_active_next = input_active_reg;
        cnt_next          = cnt_reg;
        rmw_addr_next     = rmw_addr_reg;
        rmw_char_next     = rmw_char_reg;
        fill_color_next   = fill_color_reg;
        fill_normal_next  = fill_normal_reg;
        cell_next         = cell_reg;
        lch_next          = lch_reg;
        s_we    = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        s_raddr = '0;
        l_we    = 1'b0;
        l_waddr = '0;
        l_wdata = '0;
        l_raddr = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                s_we    = 1'b1;
                s_waddr = cnt_reg;
                if (cnt_reg < STATUS_BASE)
                begin
                    s_wdata = {SCREEN_COLOR_RST, 8'd0};
                end
                else if (status_col_addr - STATUS_BASE < ADDR_W'(NORMAL_LEN))
                begin
                    s_wdata = {STATUS_COLOR_RST,
                               NORMAL_TEXT[NT_W'(cnt_reg - STATUS_BASE)]};
                end
                else
                begin
                    s_wdata = {STATUS_COLOR_RST, 8'd0};
                end
                if (cnt_reg < ADDR_W'(LINE_DEPTH))
                begin
                    l_we    = 1'b1;
                    l_waddr = cnt_reg[LINE_W-1:0];
                end
                cnt_next = (cnt_reg == ADDR_W'(CELL_COUNT - 1)) ? '0 : cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cell_next = '0;
                    lch_next  = '0;
                    cnt_next  = '0;
                    unique case (opcode)
                        OP_WRITE_CHAR:
                        begin
                            if (char_code == CH_NL || (char_code >= CH_SPACE && col_last))
                            begin
                                console_col_next = '0;
                                if (!row_last)
                                begin
                                    console_row_next = console_row_reg + 1'b1;
                                end
                            end
                            else if (char_code >= CH_SPACE)
                            begin
                                console_col_next = console_col_reg + 1'b1;
                            end
                            if (char_code >= CH_SPACE)
                            begin
                                s_we    = 1'b1;
                                s_waddr = cursor_lin;
                                s_wdata = {attr, char_code};
                            end
                        end
                        OP_KEY:
                        begin
                            if (char_code == CH_BS)
                            begin
                                rmw_addr_next = STATUS_BASE + ADDR_W'(edit_col_reg) - 1'b1;
                                rmw_char_next = '0;
                                if (input_active_reg && edit_col_reg > edit_start_reg)
                                begin
                                    edit_col_next = edit_col_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                rmw_addr_next = STATUS_BASE + ADDR_W'(edit_col_reg);
                                rmw_char_next = char_code;
                                if (input_active_reg && ch_print &&
                                    edit_col_reg < COL_W'(COLUMNS - 1))
                                begin
                                    edit_col_next = edit_col_reg + 1'b1;
                                end
                            end
                        end
                        OP_BEGIN_INPUT:
                        begin
                            input_active_next = 1'b1;
                            line_done_next    = 1'b0;
                            fill_color_next   = prompt_color_reg;
                            fill_normal_next  = 1'b0;
                            if (index < 11'(COLUMNS - 2))
                            begin
                                edit_start_next = index[COL_W-1:0];
                                edit_col_next   = index[COL_W-1:0];
                            end
                            else
                            begin
                                edit_start_next = COL_W'(COLUMNS - 2);
                                edit_col_next   = COL_W'(COLUMNS - 2);
                            end
                        end
                        OP_STATUS_WRITE:
                        begin
                            rmw_addr_next = STATUS_BASE + ADDR_W'(index[COL_W-1:0]);
                            rmw_char_next = char_code;
                        end
                        OP_READ_CELL:
                        begin
                            s_raddr = index;
                        end
                        OP_READ_LINE:
                        begin
                            l_raddr = index[LINE_W-1:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // read one row ahead, write the cell read last cycle
                if (cnt_reg < SCROLL_LEN)
                begin
                    s_raddr = cnt_reg + ADDR_W'(COLUMNS);
                end
                if (cnt_reg != '0)
                begin
                    s_we    = 1'b1;
                    s_waddr = cnt_reg - 1'b1;
                    s_wdata = (cnt_reg - 1'b1 < SCROLL_LEN) ? s_rdata : 16'd0;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_RMW_RD:
            begin
                s_raddr = rmw_addr_reg;
            end
            ST_RMW_WR:
            begin
                s_we    = 1'b1;
                s_waddr = rmw_addr_reg;
                s_wdata = {s_rdata[15:8], rmw_char_reg};
            end
            ST_CAP_RD:
            begin
                s_raddr = STATUS_BASE + ADDR_W'(cap_col);
            end
            ST_CAP_WR:
            begin
                l_we     = 1'b1;
                l_waddr  = cnt_reg[LINE_W-1:0];
                l_wdata  = s_rdata[7:0];
                cnt_next = cnt_reg + 1'b1;
            end
            ST_CAP_END:
            begin
                l_we              = 1'b1;
                l_waddr           = LINE_W'(LINE_DEPTH - 1);
                line_done_next    = 1'b1;
                input_active_next = 1'b0;
                fill_color_next   = status_color_reg;
                fill_normal_next  = 1'b1;
                cnt_next          = '0;
            end
            ST_FILL:
            begin
                s_we    = 1'b1;
                s_waddr = STATUS_BASE + cnt_reg;
                if (fill_normal_reg && cnt_reg < ADDR_W'(NORMAL_LEN))
                begin
                    s_wdata = {fill_color_reg, text_char};
                end
                else
                begin
                    s_wdata = {fill_color_reg, 8'd0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_RD_CELL:
            begin
                cell_next = s_rdata;
            end
            ST_RD_LINE:
            begin
                lch_next = l_rdata;
            end
            ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            console_col_reg  <= '0;
            console_row_reg  <= '0;
            edit_col_reg     <= '0;
            edit_start_reg   <= '0;
            line_done_reg    <= 1'b0;
            input_active_reg <= 1'b0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            console_col_reg  <= console_col_next;
            console_row_reg  <= console_row_next;
            edit_col_reg     <= edit_col_next;
            edit_start_reg   <= edit_start_next;
            line_done_reg    <= line_done_next;
            input_active_reg <= input_active_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign out_valid_next = resp_load || (out_valid_reg && out_stall);

    // payload registers
    always_ff @(posedge clk)
    begin
        rmw_addr_reg    <= rmw_addr_next;
        rmw_char_reg    <= rmw_char_next;
        fill_color_reg  <= fill_color_next;
        fill_normal_reg <= fill_normal_next;
        cell_reg        <= cell_next;
        lch_reg         <= lch_next;
        if (resp_load)
        begin
            cursor_out_reg <= input_active_reg ? (STATUS_BASE + ADDR_W'(edit_col_reg))
                                               : cursor_lin;
            cell_out_reg   <= cell_reg;
            lch_out_reg    <= lch_reg;
            ready_out_reg  <= line_done_reg;
            mode_out_reg   <= input_active_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_pos    = cursor_out_reg;
    assign cell_word     = cell_out_reg;
    assign line_char     = lch_out_reg;
    assign line_ready    = ready_out_reg;
    assign in_input_mode = mode_out_reg;

    // screen memory
    tcs_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // captured line buffer
    tcs_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

endmodule

@@ rtl/tcs_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tcs_checker.sv @@
// port level checker for the text console, bound to the top level
`timescale 1ns / 1ps
`include "text_console_with_status_input_macros.svh"

module tcs_checker
    import tcs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [10:0] cursor_pos,
    input logic        in_input_mode
);

    // a held result stays offered
    `TCS_ASSERT_NEXT(held_result_stays, out_valid && out_stall, out_valid)
    // one item at a time: busy right after an accept
    `TCS_ASSERT_NEXT(busy_after_accept, in_valid && !in_stall, in_stall)
    // console cursor stays inside the console rows
    `TCS_ASSERT_NOW(console_cursor_range, out_valid && !in_input_mode,
        cursor_pos < 11'(STATUS_START))
    // edit cursor stays on the status row
    `TCS_ASSERT_NOW(edit_cursor_range, out_valid && in_input_mode,
        cursor_pos >= 11'(STATUS_START) && cursor_pos < 11'(CELL_COUNT))

endmodule

bind text_console_with_status_input tcs_checker u_tcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cursor_pos    (cursor_pos),
    .in_input_mode (in_input_mode)
);

@@ tb/text_console_with_status_input_tb.sv @@
// self-checking testbench of the text console with status input line
`timescale 1ns / 1ps

module text_console_with_status_input_tb;
    import tcs_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_WAIT  = 300;
    localparam int ITEM_TARGET  = 550;

    typedef struct packed {
        logic [10:0] cursor;
        logic [15:0] cell_val;
        logic [7:0]  lch;
        logic        ready;
        logic        mode;
    } console_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [7:0]  char_code;
    logic [7:0]  attr;
    logic [10:0] index;
    logic        out_valid;
    logic        out_stall;
    logic [10:0] cursor_pos;
    logic [15:0] cell_word;
    logic [7:0]  line_char;
    logic        line_ready;
    logic        in_input_mode;

    text_console_with_status_input dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .char_code(char_code), .attr(attr), .index(index),
        .out_valid(out_valid), .out_stall(out_stall),
        .cursor_pos(cursor_pos), .cell_word(cell_word), .line_char(line_char),
        .line_ready(line_ready), .in_input_mode(in_input_mode)
    );

    // shadow copy of the console state
    logic [15:0] shadow_cells [CELL_COUNT];
    logic [7:0]  shadow_line [LINE_DEPTH];
    int          con_col, con_row, ed_col, ed_start;
    bit          done_flag, input_flag;
    logic [7:0]  status_c, prompt_c, screen_c;

    console_result_t pending_results[$];
    int  mismatches;
    int  items_sent;
    int  idle_cycles;
    int  hold_request;
    bit  calm_sender;
    bit  calm_receiver;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic paint_status(input logic [7:0] color);
        for (int i = 0; i < COLUMNS; i++)
            shadow_cells[STATUS_START + i] = {color, 8'h00};
    endtask

    task automatic restore_normal();
        input_flag = 1'b0;
        paint_status(status_c);
        for (int i = 0; i < NORMAL_LEN; i++)
            shadow_cells[STATUS_START + i][7:0] = NORMAL_TEXT[i];
    endtask

    task automatic shadow_reset();
        for (int i = 0; i < STATUS_START; i++)
            shadow_cells[i] = {screen_c, 8'h00};
        for (int i = 0; i < LINE_DEPTH; i++)
            shadow_line[i] = 8'h00;
        con_col = 0;
        con_row = 0;
        ed_col = 0;
        ed_start = 0;
        done_flag = 1'b0;
        restore_normal();
    endtask

    // move to the next console row, scrolling when past the bottom
    task automatic advance_row();
        con_row++;
        if (con_row >= CONSOLE_ROWS)
        begin
            con_row = CONSOLE_ROWS - 1;
            for (int i = 0; i < STATUS_START - COLUMNS; i++)
                shadow_cells[i] = shadow_cells[i + COLUMNS];
            for (int i = STATUS_START - COLUMNS; i < STATUS_START; i++)
                shadow_cells[i] = 16'h0000;
        end
    endtask

    task automatic put_console(input logic [7:0] ch, input logic [7:0] color);
        if (ch == CH_NL)
        begin
            advance_row();
            con_col = 0;
        end
        else if (ch >= CH_SPACE)
        begin
            shadow_cells[con_row * COLUMNS + con_col] = {color, ch};
            con_col++;
            if (con_col >= COLUMNS)
            begin
                advance_row();
                con_col = 0;
            end
        end
    endtask

    task automatic press_key(input logic [7:0] ch);
        if (!input_flag)
            return;
        if (ch == CH_NL)
        begin
            for (int i = 0; i + ed_start < COLUMNS && i < LINE_DEPTH; i++)
            begin
                shadow_line[i] = shadow_cells[STATUS_START + ed_start + i][7:0];
                if (shadow_line[i] == CH_NUL)
                    break;
            end
            shadow_line[LINE_DEPTH - 1] = 8'h00;
            done_flag = 1'b1;
            restore_normal();
        end
        else if (ch == CH_BS)
        begin
            if (ed_col > ed_start)
            begin
                ed_col--;
                shadow_cells[STATUS_START + ed_col][7:0] = 8'h00;
            end
        end
        else if (ch >= CH_SPACE && ch <= CH_DEL)
        begin
            if (ed_col < COLUMNS - 1)
            begin
                shadow_cells[STATUS_START + ed_col][7:0] = ch;
                ed_col++;
            end
        end
    endtask

    // apply one item to the shadow state and return the expected result
    task automatic console_predict(input logic [2:0] op, input logic [7:0] ch,
                                   input logic [7:0] color, input logic [10:0] idx,
                                   output console_result_t res);
        int cur;
        res = '0;
        case (op)
            OP_WRITE_CHAR: put_console(ch, color);
            OP_KEY: press_key(ch);
            OP_BEGIN_INPUT:
            begin
                input_flag = 1'b1;
                paint_status(prompt_c);
                ed_start = (idx < COLUMNS - 2) ? int'(idx) : COLUMNS - 2;
                ed_col = ed_start;
                done_flag = 1'b0;
            end
            OP_STATUS_WRITE:
                if (idx < COLUMNS)
                    shadow_cells[STATUS_START + idx][7:0] = ch;
            OP_READ_CELL:
                if (idx < CELL_COUNT)
                    res.cell_val = shadow_cells[idx];
            OP_READ_LINE:
                if (idx < LINE_DEPTH)
                    res.lch = shadow_line[idx];
            default: ;
        endcase
        cur = input_flag ? STATUS_START + ed_col : con_row * COLUMNS + con_col;
        res.cursor = cur[10:0];
        res.ready = done_flag;
        res.mode = input_flag;
    endtask

    function automatic int pick_gap();
        if (calm_sender || $urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // offer one item and wait until it is taken
    task automatic send_item(input logic [2:0] op, input logic [7:0] ch,
                             input logic [7:0] color, input logic [10:0] idx);
        int gap;
        console_result_t res;
        gap = pick_gap();
        for (int i = 0; i < gap; i++)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode <= op;
        char_code <= ch;
        attr <= color;
        index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        console_predict(op, ch, color, idx, res);
        pending_results.push_back(res);
        items_sent++;
    endtask

    // let the block run dry before touching registers
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] which, input logic [7:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (which)
            REG_SCREEN_COLOR: screen_c = value;
            REG_STATUS_COLOR: status_c = value;
            REG_PROMPT_COLOR: prompt_c = value;
            default: ;
        endcase
    endtask

    // reset screen, status text, out-of-range reads and spare opcodes
    task automatic test_reset_state();
        send_item(OP_READ_CELL, 8'h00, 8'h00, 11'd0);
        send_item(OP_READ_CELL, 8'hff, 8'hff, 11'(STATUS_START));
        send_item(OP_READ_CELL, 8'h00, 8'h00, 11'(STATUS_START + 11));
        send_item(OP_READ_CELL, 8'h00, 8'h00, 11'(CELL_COUNT - 1));
        send_item(OP_READ_CELL, 8'h00, 8'h00, 11'(CELL_COUNT));
        send_item(OP_READ_CELL, 8'h00, 8'h00, 11'h7ff);
        send_item(OP_READ_LINE, 8'h00, 8'h00, 11'd0);
        send_item(OP_SPARE_6, 8'h55, 8'haa, 11'h555);
        send_item(OP_SPARE_7, 8'haa, 8'h55, 11'h2aa);
    endtask

    // printable, control and high codes, wrap and scroll
    task automatic test_console();
        send_item(OP_WRITE_CHAR, CH_SPACE, 8'h00, 11'd0);
        send_item(OP_WRITE_CHAR, 8'hff, 8'hff, 11'h7ff);
        send_item(OP_WRITE_CHAR, 8'h1f, 8'h12, 11'd0);
        send_item(OP_WRITE_CHAR, CH_NUL, 8'h12, 11'd0);
        send_item(OP_WRITE_CHAR, 8'h80, 8'h4e, 11'd0);
        send_item(OP_KEY, 8'h41, 8'h00, 11'd0);
        send_item(OP_KEY, CH_NL, 8'h00, 11'd0);
        for (int i = 0; i < COLUMNS; i++)
            send_item(OP_WRITE_CHAR, 8'(8'h21 + i), 8'(i), 11'd0);
        for (int i = 0; i < CONSOLE_ROWS + 2; i++)
            send_item(OP_WRITE_CHAR, CH_NL, 8'h00, 11'd0);
        for (int i = 0; i < COLUMNS; i++)
            send_item(OP_WRITE_CHAR, 8'h61, 8'h1e, 11'd0);
        send_item(OP_READ_CELL, 8'h00, 8'h00, 11'(STATUS_START - COLUMNS - 1));
        send_item(OP_READ_CELL, 8'h00, 8'h00, 11'(STATUS_START - 1));
    endtask

    // status editing: bounds of the edit column, backspace, enter
    task automatic test_status_edit();
        send_item(OP_BEGIN_INPUT, 8'h00, 8'h00, 11'd0);
        send_item(OP_KEY, CH_BS, 8'h00, 11'd0);
        send_item(OP_KEY, 8'h80, 8'h00, 11'd0);
        send_item(OP_KEY, 8'h01, 8'h00, 11'd0);
        send_item(OP_KEY, CH_SPACE, 8'h00, 11'd0);
        send_item(OP_KEY, CH_DEL, 8'h00, 11'd0);
        send_item(OP_KEY, 8'h5a, 8'h00, 11'd0);
        send_item(OP_KEY, CH_BS, 8'h00, 11'd0);
        send_item(OP_STATUS_WRITE, 8'hff, 8'h00, 11'(COLUMNS - 1));
        send_item(OP_STATUS_WRITE, 8'h51, 8'h00, 11'(COLUMNS));
        send_item(OP_STATUS_WRITE, 8'h51, 8'h00, 11'h7ff);
        send_item(OP_KEY, CH_NL, 8'h00, 11'd0);
        send_item(OP_READ_LINE, 8'h00, 8'h00, 11'd1);
        send_item(OP_READ_LINE, 8'h00, 8'h00, 11'(LINE_DEPTH - 1));
        send_item(OP_READ_LINE, 8'h00, 8'h00, 11'(LINE_DEPTH));
        send_item(OP_READ_LINE, 8'h00, 8'h00, 11'h7ff);
        // prompt clamped to the last usable column
        send_item(OP_BEGIN_INPUT, 8'h00, 8'h00, 11'h7ff);
        send_item(OP_KEY, 8'h41, 8'h00, 11'd0);
        send_item(OP_KEY, 8'h42, 8'h00, 11'd0);
        send_item(OP_KEY, CH_NL, 8'h00, 11'd0);
        send_item(OP_READ_LINE, 8'h00, 8'h00, 11'd0);
        send_item(OP_BEGIN_INPUT, 8'h00, 8'h00, 11'(COLUMNS - 2));
        send_item(OP_STATUS_WRITE, 8'h00, 8'h00, 11'(COLUMNS - 2));
        send_item(OP_KEY, CH_NL, 8'h00, 11'd0);
        send_item(OP_READ_LINE, 8'h00, 8'h00, 11'd0);
    endtask

    // one random edit session, mostly well formed
    task automatic random_session();
        int keys;
        logic [7:0] key;
        send_item(OP_BEGIN_INPUT, 8'($urandom), 8'($urandom),
                  ($urandom_range(0, 4) == 0) ? 11'($urandom) : 11'($urandom_range(0, 20)));
        keys = $urandom_range(0, 25);
        for (int k = 0; k < keys; k++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: key = CH_BS;
                3: key = 8'($urandom);
                4:
                begin
                    send_item(OP_STATUS_WRITE, 8'($urandom), 8'($urandom),
                              11'($urandom_range(0, COLUMNS + 3)));
                    continue;
                end
                5:
                begin
                    send_item(OP_READ_CELL, 8'($urandom), 8'($urandom),
                              11'($urandom_range(STATUS_START, CELL_COUNT - 1)));
                    continue;
                end
                default: key = 8'($urandom_range(CH_SPACE, CH_DEL));
            endcase
            send_item(OP_KEY, key, 8'($urandom), 11'($urandom));
        end
        if ($urandom_range(0, 4) != 0)
            send_item(OP_KEY, CH_NL, 8'($urandom), 11'($urandom));
        for (int k = $urandom_range(0, 4); k > 0; k--)
            send_item(OP_READ_LINE, 8'($urandom), 8'($urandom),
                      ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 15)));
    endtask

    task automatic random_console();
        logic [7:0] ch;
        for (int k = $urandom_range(1, 12); k > 0; k--)
        begin
            case ($urandom_range(0, 9))
                0: ch = CH_NL;
                1: ch = 8'($urandom_range(0, 8'h1f));
                default: ch = 8'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0)
                send_item(OP_READ_CELL, 8'($urandom), 8'($urandom), 11'($urandom));
            else
                send_item(OP_WRITE_CHAR, ch, 8'($urandom), 11'($urandom));
        end
    endtask

    task automatic test_random(input int target);
        while (items_sent < target)
        begin
            case ($urandom_range(0, 5))
                0, 1: random_session();
                2, 3: random_console();
                4: send_item(3'($urandom), 8'($urandom), 8'($urandom), 11'($urandom));
                default: send_item(OP_READ_CELL, 8'($urandom), 8'($urandom),
                                   11'($urandom_range(0, CELL_COUNT + 47)));
            endcase
        end
    endtask

    // register settings, extremes included, then a session under each
    task automatic test_config();
        logic [7:0] extremes [3] = '{8'h00, 8'hff, 8'h5a};
        for (int s = 0; s < 3; s++)
        begin
            wait_drained();
            write_reg(REG_SCREEN_COLOR, extremes[s]);
            write_reg(REG_STATUS_COLOR, extremes[(s + 1) % 3]);
            write_reg(REG_PROMPT_COLOR, extremes[(s + 2) % 3]);
            write_reg(REG_UNUSED, 8'($urandom));
            random_session();
            send_item(OP_BEGIN_INPUT, 8'h00, 8'h00, 11'd3);
            send_item(OP_KEY, CH_NL, 8'h00, 11'd0);
            send_item(OP_READ_CELL, 8'h00, 8'h00, 11'(STATUS_START + 4));
        end
        wait_drained();
        write_reg(REG_STATUS_COLOR, 8'($urandom));
        write_reg(REG_PROMPT_COLOR, 8'($urandom));
    endtask

    // receiver holds off long while items keep coming, then a run with no receiver stall
    task automatic test_backpressure();
        wait_drained();
        calm_sender = 1'b1;
        hold_request = 3000;
        for (int k = 0; k < 20; k++)
            send_item(OP_WRITE_CHAR, 8'($urandom_range(CH_SPACE, 8'hff)), 8'($urandom),
                      11'd0);
        calm_sender = 1'b0;
        wait_drained();
        calm_receiver = 1'b1;
        test_random(items_sent + 40);
        calm_receiver = 1'b0;
    endtask

    // receiver stall pattern
    initial
    begin
        int run_left;
        run_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                out_stall <= 1'b1;
                hold_request--;
            end
            else if (calm_receiver)
                out_stall <= 1'b0;
            else if (run_left > 0)
                run_left--;
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(0, 3);
            end
        end
    end

    // result checker
    initial
    begin
        console_result_t want;
        console_result_t got;
        mismatches = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{cursor_pos, cell_word, line_char, line_ready, in_input_mode};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %p", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SCREEN_COLOR;
        cfg_data = 8'h00;
        in_valid = 1'b0;
        opcode = OP_WRITE_CHAR;
        char_code = 8'h00;
        attr = 8'h00;
        index = 11'd0;
        items_sent = 0;
        hold_request = 0;
        calm_sender = 1'b0;
        calm_receiver = 1'b0;
        screen_c = SCREEN_COLOR_RST;
        status_c = STATUS_COLOR_RST;
        prompt_c = PROMPT_COLOR_RST;
        shadow_reset();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_console();
        test_status_edit();
        test_config();
        test_backpressure();
        test_random(ITEM_TARGET);
        wait_drained();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
